// ----- rtl/core/price_level_book_engine_macros.svh -----
// Assertion macros shared by the price level book engine RTL.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef PRICE_LEVEL_BOOK_ENGINE_MACROS_SVH
`define PRICE_LEVEL_BOOK_ENGINE_MACROS_SVH

// same-cycle implication
`define PLBE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("plbe assertion failed: same-cycle rule");

// next-cycle implication
`define PLBE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("plbe assertion failed: next-cycle rule");

`endif

// ----- rtl/core/plbe_pkg.sv -----
// Types and codes of the price level book engine.
// No dependencies; used by every module of the block.
package plbe_pkg;

    localparam logic [1:0] REQ_BEGIN  = 2'd0;
    localparam logic [1:0] REQ_LEVEL  = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;
    localparam logic [1:0] REQ_UPDATE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_PRECOND  = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;

    localparam logic [2:0] VIOL_NONE     = 3'd0;
    localparam logic [2:0] VIOL_CROSSED  = 3'd1;
    localparam logic [2:0] VIOL_LOCKED   = 3'd2;
    localparam logic [2:0] VIOL_NEG_QTY  = 3'd3;
    localparam logic [2:0] VIOL_BAD_PX   = 3'd4;
    localparam logic [2:0] VIOL_DUP      = 3'd5;
    localparam logic [2:0] VIOL_SEQ      = 3'd6;

    localparam int IN_DATA_W  = 200;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 360;

    typedef enum logic [2:0] {
        SOP_NONE,
        SOP_BOOK_INS,
        SOP_BOOK_DEL,
        SOP_BOOK_REP,
        SOP_STG_INS,
        SOP_STG_CLR,
        SOP_COPY
    } t_side_op;

    typedef struct packed {
        logic     search;
        logic     decide;
        logic     stage_sel;
        t_side_op op;
    } t_side_cmd;

    typedef struct packed {
        logic found;
        logic pos_lt_n;
    } t_side_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_APPLY,
        S_FINAL
    } t_state;

    typedef struct packed {
        logic load_in;
        logic search;
        logic decide;
        logic apply;
        logic out_load;
    } t_dp_cmd;

endpackage

// ----- rtl/core/plbe_side.sv -----
// One side of the book: live levels and staged snapshot levels as a row of cells.
// Parallel compare, then shift-insert / shift-erase / replace / copy. Uses plbe_pkg.
module plbe_side #(
    parameter int DEPTH      = 64,
    parameter int PRICE_BITS = 64,
    parameter int QTY_BITS   = 64,
    parameter int CW         = $clog2(DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_is_ask,
    input  plbe_pkg::t_side_cmd           i_cmd,
    input  logic signed [PRICE_BITS-1:0]  i_price,
    input  logic signed [QTY_BITS-1:0]    i_qty,
    input  logic [CW-1:0]                 i_depth,
    output plbe_pkg::t_side_stat          o_stat,
    output logic [CW-1:0]                 o_bcnt,
    output logic [CW-1:0]                 o_scnt,
    output logic signed [PRICE_BITS-1:0]  o_top_bp,
    output logic signed [QTY_BITS-1:0]    o_top_bq,
    output logic signed [PRICE_BITS-1:0]  o_top_sp
);
    import plbe_pkg::*;

    logic signed [PRICE_BITS-1:0] r_bp [DEPTH];
    logic signed [QTY_BITS-1:0]   r_bq [DEPTH];
    logic signed [PRICE_BITS-1:0] r_sp [DEPTH];
    logic signed [QTY_BITS-1:0]   r_sq [DEPTH];
    logic [CW-1:0]                r_bcnt, r_scnt;
    logic [DEPTH-1:0]             r_ge, r_hit, r_eq;
    logic [DEPTH-1:0]             n_ge, n_hit, n_eq, at_pos;
    logic                         r_found, r_pos_lt_n;
    logic [CW-1:0]                cur_n;

    assign cur_n = i_cmd.stage_sel ? r_scnt : r_bcnt;

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_lane
            logic signed [PRICE_BITS-1:0] cp;
            logic lt_n, better;
            always_comb begin
                cp     = i_cmd.stage_sel ? r_sp[k] : r_bp[k];
                lt_n   = CW'(k) < cur_n;
                better = i_is_ask ? (cp < i_price) : (cp > i_price);
                n_ge[k]  = !lt_n || !better;
                n_hit[k] = lt_n && !better;
                n_eq[k]  = lt_n && (cp == i_price);
            end

            if (k == 0) begin : g_first
                assign at_pos[k] = r_ge[k];
            end else begin : g_rest
                assign at_pos[k] = r_ge[k] && !r_ge[k-1];
            end

            always_ff @(posedge i_clk) begin
                case (i_cmd.op)
                    SOP_BOOK_INS: begin
                        if (at_pos[k]) begin
                            r_bp[k] <= i_price;
                            r_bq[k] <= i_qty;
                        end else if (r_ge[k] && k > 0) begin
                            r_bp[k] <= r_bp[(k > 0) ? k - 1 : 0];
                            r_bq[k] <= r_bq[(k > 0) ? k - 1 : 0];
                        end
                    end
                    SOP_BOOK_DEL: begin
                        if (r_ge[k] && k + 1 < DEPTH) begin
                            r_bp[k] <= r_bp[(k + 1 < DEPTH) ? k + 1 : k];
                            r_bq[k] <= r_bq[(k + 1 < DEPTH) ? k + 1 : k];
                        end
                    end
                    SOP_BOOK_REP: begin
                        if (at_pos[k]) begin
                            r_bq[k] <= i_qty;
                        end
                    end
                    SOP_STG_INS: begin
                        if (at_pos[k]) begin
                            r_sp[k] <= i_price;
                            r_sq[k] <= i_qty;
                        end else if (r_ge[k] && k > 0) begin
                            r_sp[k] <= r_sp[(k > 0) ? k - 1 : 0];
                            r_sq[k] <= r_sq[(k > 0) ? k - 1 : 0];
                        end
                    end
                    SOP_COPY: begin
                        r_bp[k] <= r_sp[k];
                        r_bq[k] <= r_sq[k];
                    end
                    default: begin
                    end
                endcase
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_cmd.search) begin
            r_ge  <= n_ge;
            r_hit <= n_hit;
            r_eq  <= n_eq;
        end
        if (i_cmd.decide) begin
            r_found    <= |r_eq;
            r_pos_lt_n <= |r_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt <= '0;
            r_scnt <= '0;
        end else begin
            case (i_cmd.op)
                SOP_BOOK_INS: r_bcnt <= (r_bcnt < i_depth) ? r_bcnt + 1'b1 : i_depth;
                SOP_BOOK_DEL: r_bcnt <= r_bcnt - 1'b1;
                SOP_STG_INS:  r_scnt <= (r_scnt == CW'(DEPTH)) ? r_scnt : r_scnt + 1'b1;
                SOP_STG_CLR:  r_scnt <= '0;
                SOP_COPY: begin
                    r_bcnt <= (r_scnt > i_depth) ? i_depth : r_scnt;
                    r_scnt <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stat.found    = r_found;
    assign o_stat.pos_lt_n = r_pos_lt_n;
    assign o_bcnt   = r_bcnt;
    assign o_scnt   = r_scnt;
    assign o_top_bp = r_bp[0];
    assign o_top_bq = r_bq[0];
    assign o_top_sp = r_sp[0];

endmodule

// ----- rtl/core/plbe_dp.sv -----
// Datapath: item registers, book flags, sequence register and drop counter, result register.
// Holds both side arrays (plbe_side). Uses plbe_pkg.
module plbe_dp #(
    parameter int DEPTH      = 64,
    parameter int PRICE_BITS = 64,
    parameter int QTY_BITS   = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  plbe_pkg::t_dp_cmd                   i_cmd,
    input  logic [plbe_pkg::IN_DATA_W-1:0]      i_tdata,
    input  logic [plbe_pkg::IN_USER_W-1:0]      i_tuser,
    input  logic                                i_tlast,
    input  logic                                i_cfg_we,
    input  logic [6:0]                          i_cfg_wdata,
    output logic [plbe_pkg::OUT_DATA_W-1:0]     o_tdata
);
    import plbe_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [1:0]                   r_rt;
    logic                         r_side, r_has, r_last;
    logic signed [PRICE_BITS-1:0] r_price;
    logic signed [QTY_BITS-1:0]   r_qty;
    logic [63:0]                  r_uid;

    logic r_building, r_applied, r_aborted, r_dup, r_chk;
    logic [2:0]  r_viol;
    logic [1:0]  r_status;
    logic [63:0] r_seq;
    logic        r_seq_vld;
    logic [31:0] r_drop;
    logic [6:0]  r_md;
    logic [OUT_DATA_W-1:0] r_out;

    logic n_building, n_applied, n_aborted, n_dup, n_chk, n_seq_vld;
    logic [2:0]  n_viol, n_viol_f;
    logic [1:0]  n_status, n_status_f;
    logic [63:0] n_seq, n_seq_f;
    logic        n_seq_vld_f;
    logic [31:0] n_drop;

    t_side_cmd  cmd_b, cmd_a;
    t_side_op   op_b, op_a;
    t_side_stat stat_b, stat_a, stat_t;
    logic [CW-1:0] bcnt, acnt, sbcnt, sacnt, depth, n_t;
    logic signed [PRICE_BITS-1:0] top_bp, top_ap, top_sbp, top_sap;
    logic signed [QTY_BITS-1:0]   top_bq, top_aq;
    logic px_bad, q_neg, q_zero, crossed;

    always_comb begin
        if (r_md == 7'd0 || 32'(r_md) > DEPTH) begin
            depth = CW'(DEPTH);
        end else begin
            depth = CW'(r_md);
        end
    end

    assign cmd_b = '{search: i_cmd.search, decide: i_cmd.decide,
                     stage_sel: (r_rt == REQ_LEVEL), op: op_b};
    assign cmd_a = '{search: i_cmd.search, decide: i_cmd.decide,
                     stage_sel: (r_rt == REQ_LEVEL), op: op_a};

    plbe_side #(.DEPTH(DEPTH), .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS)) u_bid (
        .i_clk, .i_rst_n, .i_is_ask(1'b0), .i_cmd(cmd_b), .i_price(r_price),
        .i_qty(r_qty), .i_depth(depth), .o_stat(stat_b), .o_bcnt(bcnt),
        .o_scnt(sbcnt), .o_top_bp(top_bp), .o_top_bq(top_bq), .o_top_sp(top_sbp)
    );

    plbe_side #(.DEPTH(DEPTH), .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS)) u_ask (
        .i_clk, .i_rst_n, .i_is_ask(1'b1), .i_cmd(cmd_a), .i_price(r_price),
        .i_qty(r_qty), .i_depth(depth), .o_stat(stat_a), .o_bcnt(acnt),
        .o_scnt(sacnt), .o_top_bp(top_ap), .o_top_bq(top_aq), .o_top_sp(top_sap)
    );

    assign stat_t = r_side ? stat_a : stat_b;
    assign n_t    = r_side ? acnt : bcnt;
    assign px_bad = r_price[PRICE_BITS-1] || (r_price == '0);
    assign q_neg  = r_qty[QTY_BITS-1];
    assign q_zero = (r_qty == '0);

    // item decision, taken in the apply step
    always_comb begin
        t_side_op op;
        logic err;
        op         = SOP_NONE;
        err        = 1'b0;
        op_b       = SOP_NONE;
        op_a       = SOP_NONE;
        n_building = r_building;
        n_applied  = r_applied;
        n_aborted  = r_aborted;
        n_dup      = r_dup;
        n_chk      = 1'b0;
        n_viol     = r_viol;
        n_status   = ST_OK;
        n_seq      = r_seq;
        n_seq_vld  = r_seq_vld;
        n_drop     = r_drop;
        case (r_rt)
            REQ_BEGIN: begin
                op_b       = SOP_STG_CLR;
                op_a       = SOP_STG_CLR;
                n_building = 1'b1;
                n_dup      = 1'b0;
            end
            REQ_LEVEL: begin
                if (!r_building) begin
                    n_status = ST_PRECOND;
                end else if (q_zero) begin
                    n_status = ST_OK;
                end else if (px_bad || q_neg) begin
                    n_status = ST_INVALID;
                end else if (stat_t.found) begin
                    n_dup = 1'b1;
                end else if (stat_t.pos_lt_n ||
                             (r_side ? sacnt : sbcnt) != CW'(DEPTH)) begin
                    op = SOP_STG_INS;
                end
            end
            REQ_FINISH: begin
                if (!r_building) begin
                    n_status = ST_PRECOND;
                end else begin
                    n_building = 1'b0;
                    if (r_dup) begin
                        n_viol   = VIOL_DUP;
                        n_status = ST_INVALID;
                    end else if (sbcnt != '0 && sacnt != '0 && top_sbp >= top_sap) begin
                        n_viol   = (top_sbp == top_sap) ? VIOL_LOCKED : VIOL_CROSSED;
                        n_status = ST_INVALID;
                    end else begin
                        op_b      = SOP_COPY;
                        op_a      = SOP_COPY;
                        n_seq     = r_has ? r_uid : 64'd0;
                        n_seq_vld = r_has;
                        n_applied = 1'b1;
                        n_aborted = 1'b0;
                        n_viol    = VIOL_NONE;
                    end
                end
            end
            default: begin
                if (!r_applied) begin
                    n_status = ST_PRECOND;
                end else if (r_aborted) begin
                    if (r_last) begin
                        n_aborted = 1'b0;
                    end
                end else begin
                    err = 1'b1;
                    if (r_has && r_seq_vld && r_uid < r_seq) begin
                        n_viol   = VIOL_SEQ;
                        n_status = ST_PRECOND;
                    end else if (px_bad) begin
                        n_viol   = VIOL_BAD_PX;
                        n_status = ST_INVALID;
                    end else if (q_neg) begin
                        n_viol   = VIOL_NEG_QTY;
                        n_status = ST_INVALID;
                    end else begin
                        err   = 1'b0;
                        n_chk = r_last;
                        if (q_zero) begin
                            if (stat_t.found) begin
                                op = SOP_BOOK_DEL;
                            end
                        end else if (stat_t.found) begin
                            op = SOP_BOOK_REP;
                        end else if (n_t >= depth && !stat_t.pos_lt_n) begin
                            n_drop = r_drop + 32'd1;
                        end else begin
                            op = SOP_BOOK_INS;
                            if (n_t >= depth) begin
                                n_drop = r_drop + 32'd1;
                            end
                        end
                    end
                    if (err && !r_last) begin
                        n_aborted = 1'b1;
                    end
                end
            end
        endcase
        if (r_rt == REQ_LEVEL || r_rt == REQ_UPDATE) begin
            if (r_side) begin
                op_a = op;
            end else begin
                op_b = op;
            end
        end
        if (!i_cmd.apply) begin
            op_b = SOP_NONE;
            op_a = SOP_NONE;
        end
    end

    // end-of-message check on the updated book
    assign crossed = r_chk && bcnt != '0 && acnt != '0 && top_bp >= top_ap;

    always_comb begin
        n_viol_f    = r_viol;
        n_status_f  = r_status;
        n_seq_f     = r_seq;
        n_seq_vld_f = r_seq_vld;
        if (crossed) begin
            n_viol_f   = (top_bp == top_ap) ? VIOL_LOCKED : VIOL_CROSSED;
            n_status_f = ST_PRECOND;
        end else if (r_chk && r_has) begin
            n_seq_f     = r_uid;
            n_seq_vld_f = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_rt    <= i_tuser[1:0];
            r_side  <= i_tuser[2];
            r_price <= i_tdata[PRICE_BITS-1:0];
            r_qty   <= i_tdata[64 +: QTY_BITS];
            r_uid   <= i_tdata[191:128];
            r_has   <= i_tdata[192];
            r_last  <= i_tlast;
        end
        if (i_cmd.out_load) begin
            r_out <= {3'b000, r_drop, (n_seq_vld_f ? n_seq_f : 64'd0),
                      (acnt != '0 ? 64'(top_aq) : 64'd0),
                      (acnt != '0 ? 64'(top_ap) : 64'd0),
                      (bcnt != '0 ? 64'(top_bq) : 64'd0),
                      (bcnt != '0 ? 64'(top_bp) : 64'd0),
                      n_viol_f, n_status_f};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_building <= 1'b0;
            r_applied  <= 1'b0;
            r_aborted  <= 1'b0;
            r_dup      <= 1'b0;
            r_chk      <= 1'b0;
            r_viol     <= VIOL_NONE;
            r_status   <= ST_OK;
            r_seq      <= '0;
            r_seq_vld  <= 1'b0;
            r_drop     <= '0;
            r_md       <= 7'd64;
        end else begin
            if (i_cfg_we) begin
                r_md <= i_cfg_wdata;
            end
            if (i_cmd.apply) begin
                r_building <= n_building;
                r_applied  <= n_applied;
                r_aborted  <= n_aborted;
                r_dup      <= n_dup;
                r_chk      <= n_chk;
                r_viol     <= n_viol;
                r_status   <= n_status;
                r_seq      <= n_seq;
                r_seq_vld  <= n_seq_vld;
                r_drop     <= n_drop;
            end else if (i_cmd.out_load) begin
                r_viol    <= n_viol_f;
                r_seq     <= n_seq_f;
                r_seq_vld <= n_seq_vld_f;
                r_chk     <= 1'b0;
            end
        end
    end

    assign o_tdata = r_out;

endmodule

// ----- rtl/core/plbe_ctrl.sv -----
// Controller: steps one item through search, decide, apply and result load.
// Owns the input ready and the result valid flag. Uses plbe_pkg and the macro header.
`include "price_level_book_engine_macros.svh"

module plbe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output plbe_pkg::t_dp_cmd o_cmd
);
    import plbe_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_s_tvalid) n_state = S_SEARCH;
            S_SEARCH: n_state = S_DECIDE;
            S_DECIDE: n_state = S_APPLY;
            S_APPLY:  n_state = S_FINAL;
            S_FINAL:  if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_s_tready     = (r_state == S_IDLE);
        o_cmd.load_in  = (r_state == S_IDLE) && i_s_tvalid;
        o_cmd.search   = (r_state == S_SEARCH);
        o_cmd.decide   = (r_state == S_DECIDE);
        o_cmd.apply    = (r_state == S_APPLY);
        o_cmd.out_load = (r_state == S_FINAL) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;

    `PLBE_ASSERT_NEXT(a_accept_starts, o_cmd.load_in, r_state == S_SEARCH)
    `PLBE_ASSERT_NEXT(a_apply_then_final, r_state == S_APPLY, r_state == S_FINAL)
    `PLBE_ASSERT_NOW(a_no_overwrite, o_cmd.out_load, !r_out_valid || i_m_tready)
    `PLBE_ASSERT_NEXT(a_load_sets_valid, o_cmd.out_load, r_out_valid)

endmodule

// ----- rtl/core/price_level_book_engine.sv -----
// Price level book engine: depth-limited bid/ask level book with snapshot staging.
// Input stream: tuser = {side, req_type}, tlast = last_in_message, tdata = level fields.
// Output stream: one result transfer per input transfer (status, violation, top of book,
// book sequence, dropped level count) in tdata.
// Configuration: i_cfg_we writes the depth limit (levels kept per side) from i_cfg_wdata.
// Flow: each input transfer steps through the states search, decide, apply and final,
// and the next input is taken only after its result is loaded. The steps are a parallel
// compare over the cell row, a reduction of the compare flags, the shift or copy of the row,
// and the end-of-message check with the result load.
// Reset (i_rst_n low at a clock edge) empties both sides and staging, clears all flags,
// the violation, sequence and drop count, and sets the depth limit to 64.
// A result waits in the output register while the receiver stalls; the next input is
// still taken and worked, and its result is held back until the register frees.
// Depends on plbe_pkg, plbe_ctrl, plbe_dp, plbe_side.
module price_level_book_engine #(
    parameter int DEPTH      = 64,
    parameter int PRICE_BITS = 64,
    parameter int QTY_BITS   = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // price[63:0], quantity[127:64], update_id[191:128], has_update_id[192], zero pad
    input  logic [plbe_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // req_type[1:0], side[2]
    input  logic [plbe_pkg::IN_USER_W-1:0]      s_axis_tuser,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // status[1:0], violation[4:2], top bid price[68:5], top bid qty[132:69],
    // top ask price[196:133], top ask qty[260:197], book_seq[324:261],
    // dropped_levels[356:325], zero pad
    output logic [plbe_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [6:0]                          i_cfg_wdata
);
    import plbe_pkg::*;

    t_dp_cmd cmd;

    plbe_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_s_tvalid(s_axis_tvalid), .o_s_tready(s_axis_tready),
        .o_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .o_cmd(cmd)
    );

    plbe_dp #(.DEPTH(DEPTH), .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd),
        .i_tdata(s_axis_tdata), .i_tuser(s_axis_tuser), .i_tlast(s_axis_tlast),
        .i_cfg_we, .i_cfg_wdata, .o_tdata(m_axis_tdata)
    );

endmodule
